>>> rtl/bfha_pkg.sv
`default_nettype none

package bfha_pkg;

    // Heap geometry. The heap size is a power of two, so byte addresses wrap by masking.
    localparam int HEAP_BYTES = 16384;
    localparam int ADDR_W     = $clog2(HEAP_BYTES);
    localparam int BANK_W     = ADDR_W - 1;
    localparam int BANK_DEPTH = HEAP_BYTES / 2;
    localparam int WORD_W     = 16;
    localparam int TOP_W      = $clog2(HEAP_BYTES + 1);

    // Free list walks stop after this many nodes.
    localparam int WALK_LIMIT = HEAP_BYTES / 4 + 1;
    localparam int IDX_W      = $clog2(WALK_LIMIT);
    localparam int CNT_W      = $clog2(WALK_LIMIT + 1);

    // End of the free list.
    localparam logic [WORD_W-1:0] NIL = 16'hFFFF;

    // Smallest remainder that is worth splitting off.
    localparam logic [WORD_W-1:0] MIN_REST = 16'd4;

    // Operation codes.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // One request to the heap storage: a read and a write, each of a 16-bit little-endian word at any byte address.
    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
    } heap_req_t;

endpackage

`default_nettype wire

>>> rtl/bfha_heap.sv
`default_nettype none

// Byte heap stored as two banks, even and odd byte addresses, so that a
// 16-bit word at any byte address is read or written in a single access.
module bfha_heap (
    input  wire logic                          clk,
    input  wire bfha_pkg::heap_req_t           req,
    output logic [bfha_pkg::WORD_W-1:0]        rd_data
);

    logic [7:0] even_mem [bfha_pkg::BANK_DEPTH];
    logic [7:0] odd_mem  [bfha_pkg::BANK_DEPTH];

    logic [7:0] even_rd_reg;
    logic [7:0] odd_rd_reg;
    logic       par_reg;

    logic [bfha_pkg::BANK_W-1:0] rd_odd_idx;
    logic [bfha_pkg::BANK_W-1:0] rd_even_idx;
    logic [bfha_pkg::BANK_W-1:0] wr_odd_idx;
    logic [bfha_pkg::BANK_W-1:0] wr_even_idx;

    // The odd byte of a word sits at addr/2; the even byte at (addr+1)/2.
    assign rd_odd_idx  = req.raddr[bfha_pkg::ADDR_W-1:1];
    assign rd_even_idx = req.raddr[bfha_pkg::ADDR_W-1:1] + bfha_pkg::BANK_W'(req.raddr[0]);
    assign wr_odd_idx  = req.waddr[bfha_pkg::ADDR_W-1:1];
    assign wr_even_idx = req.waddr[bfha_pkg::ADDR_W-1:1] + bfha_pkg::BANK_W'(req.waddr[0]);

    // Write both bytes; the low byte goes to the bank of the address parity.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            if (req.waddr[0])
            begin
                odd_mem[wr_odd_idx]   <= req.wdata[7:0];
                even_mem[wr_even_idx] <= req.wdata[15:8];
            end
            else
            begin
                even_mem[wr_even_idx] <= req.wdata[7:0];
                odd_mem[wr_odd_idx]   <= req.wdata[15:8];
            end
        end
    end

    // Registered read of both banks.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            even_rd_reg <= even_mem[rd_even_idx];
            odd_rd_reg  <= odd_mem[rd_odd_idx];
            par_reg     <= req.raddr[0];
        end
    end

    // Put the bytes back in little-endian order.
    assign rd_data = par_reg ? {even_rd_reg, odd_rd_reg} : {odd_rd_reg, even_rd_reg};

endmodule

`default_nettype wire

>>> rtl/best_fit_heap_allocator.sv
// Best-fit allocator over a 16 KiB byte heap whose block headers live in the
// heap itself: a 16-bit size word, and for free blocks a 16-bit link to the next
// free block. Each word brings one allocate or release and gives one result word
// with the status, the payload offset and the current use, peak and top of the
// heap. One request is handled at a time and its duration depends on the data,
// because all list work goes through the heap banks and a node buffer, each with
// one access per cycle. An allocation walks the free list for the best fit and,
// if none fits, cuts the block from the top; a release at the top lowers the top.
// Any other release rebuilds the free list: it collects the list into the node
// buffer, runs an insertion sort by address (quadratic in the list length in the
// worst case, linear when the list is already ordered), drops duplicates, merges
// each surviving block with its adjacent neighbors, and relinks the list.
// A new request word is taken while the previous result still waits to be read.
`default_nettype none

module best_fit_heap_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic        op,
    input  wire logic [15:0] request_bytes,
    input  wire logic [13:0] release_offset,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic             ok,
    output logic [13:0]      payload_offset,
    output logic [14:0]      bytes_in_use,
    output logic [14:0]      peak_top,
    output logic [14:0]      top_pointer
);

    localparam int AW = bfha_pkg::ADDR_W;
    localparam int WW = bfha_pkg::WORD_W;
    localparam int TW = bfha_pkg::TOP_W;
    localparam int CW = bfha_pkg::CNT_W;
    localparam int IW = bfha_pkg::IDX_W;

    localparam logic [WW-1:0] DIFF_NONE = 16'hFFFF;

    localparam logic [5:0] S_IDLE       = 6'd0;
    localparam logic [5:0] S_DISPATCH   = 6'd1;
    localparam logic [5:0] S_TB_CHECK   = 6'd2;
    localparam logic [5:0] S_TB_SIZE    = 6'd3;
    localparam logic [5:0] S_TB_NEXT    = 6'd4;
    localparam logic [5:0] S_TB_END     = 6'd5;
    localparam logic [5:0] S_SPLIT_RD   = 6'd6;
    localparam logic [5:0] S_SPLIT_WR   = 6'd7;
    localparam logic [5:0] S_SPLIT_LINK = 6'd8;
    localparam logic [5:0] S_TB_UNLINK  = 6'd9;
    localparam logic [5:0] S_TB_RELINK  = 6'd10;
    localparam logic [5:0] S_ALLOC_TOP  = 6'd11;
    localparam logic [5:0] S_ALLOC_FIN  = 6'd12;
    localparam logic [5:0] S_REL_SIZE   = 6'd13;
    localparam logic [5:0] S_DF_CHECK   = 6'd14;
    localparam logic [5:0] S_DF_NEXT    = 6'd15;
    localparam logic [5:0] S_SO_CHECK   = 6'd16;
    localparam logic [5:0] S_SO_LOADV   = 6'd17;
    localparam logic [5:0] S_SO_CMP     = 6'd18;
    localparam logic [5:0] S_SO_TEST    = 6'd19;
    localparam logic [5:0] S_DD_CHECK   = 6'd20;
    localparam logic [5:0] S_DD_TEST    = 6'd21;
    localparam logic [5:0] S_CO_CHECK   = 6'd22;
    localparam logic [5:0] S_CO_C       = 6'd23;
    localparam logic [5:0] S_CO_SZ      = 6'd24;
    localparam logic [5:0] S_CO_JCHK    = 6'd25;
    localparam logic [5:0] S_CO_JTEST   = 6'd26;
    localparam logic [5:0] S_CO_ADD     = 6'd27;
    localparam logic [5:0] S_CO_WR      = 6'd28;
    localparam logic [5:0] S_LK_START   = 6'd29;
    localparam logic [5:0] S_LK_FIRST   = 6'd30;
    localparam logic [5:0] S_LK_CHECK   = 6'd31;
    localparam logic [5:0] S_LK_WR      = 6'd32;
    localparam logic [5:0] S_EMIT       = 6'd33;

    // Heap index of a 16-bit address, wrapped to the heap.
    function automatic logic [AW-1:0] word_index(input logic [WW-1:0] a);
        return a[AW-1:0];
    endfunction

    // Heap index of the link word, two bytes past a block start.
    function automatic logic [AW-1:0] link_index(input logic [WW-1:0] a);
        logic [WW:0] s;
        s = {1'b0, a} + 17'd2;
        return s[AW-1:0];
    endfunction

    // Control and architectural state.
    logic [5:0]    state_reg, state_next;
    logic [TW-1:0] top_reg, top_next;
    logic [WW-1:0] head_reg, head_next;
    logic [TW-1:0] live_reg, live_next;
    logic [TW-1:0] peak_reg, peak_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // Working registers.
    logic          op_reg, op_next;
    logic [WW-1:0] req_reg, req_next;
    logic [AW-1:0] rel_reg, rel_next;
    logic [WW:0]   size_reg, size_next;
    logic [WW-1:0] cur_reg, cur_next;
    logic [WW-1:0] prev_reg, prev_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic [WW-1:0] best_reg, best_next;
    logic [WW-1:0] fit_pred_reg, fit_pred_next;
    logic [WW-1:0] fit_slack_reg, fit_slack_next;
    logic [WW-1:0] best_size_reg, best_size_next;
    logic          found_reg, found_next;
    logic [WW-1:0] rest_reg, rest_next;
    logic [WW-1:0] blk_reg, blk_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [WW-1:0] v_reg, v_next;
    logic [WW-1:0] last_reg, last_next;
    logic [WW-1:0] c_reg, c_next;
    logic [WW-1:0] sz_reg, sz_next;
    logic          ok_w_reg, ok_w_next;
    logic [AW-1:0] pay_w_reg, pay_w_next;

    // Result word.
    logic          res_ok_reg, res_ok_next;
    logic [AW-1:0] res_pay_reg, res_pay_next;
    logic [TW-1:0] res_live_reg, res_live_next;
    logic [TW-1:0] res_peak_reg, res_peak_next;
    logic [TW-1:0] res_top_reg, res_top_next;

    // Heap storage access.
    bfha_pkg::heap_req_t hp_req;
    logic [WW-1:0]       hp_rdata;

    // Node buffer, used to sort and merge the free list.
    logic [WW-1:0] nb_mem [bfha_pkg::WALK_LIMIT];
    logic [WW-1:0] nb_rd_reg;
    logic          nb_re;
    logic [IW-1:0] nb_raddr;
    logic          nb_we;
    logic [IW-1:0] nb_waddr;
    logic [WW-1:0] nb_wdata;

    // Derived values.
    logic [WW-1:0] req_pad;
    logic [WW:0]   pad_size;
    logic [WW-1:0] size16;
    logic          blk_fits;
    logic [WW-1:0] blk_diff;
    logic          take_blk;
    logic [WW:0]   rest_sum;
    logic [AW-1:0] hdr;
    logic [WW:0]   rel_end;
    logic [WW+1:0] top_room;
    logic [WW:0]   coal_end;
    logic [CW-1:0] j_dec;

    bfha_heap u_heap (
        .clk     (clk),
        .req     (hp_req),
        .rd_data (hp_rdata)
    );

    // Node buffer memory.
    always_ff @(posedge clk)
    begin
        if (nb_we)
        begin
            nb_mem[nb_waddr] <= nb_wdata;
        end
        if (nb_re)
        begin
            nb_rd_reg <= nb_mem[nb_raddr];
        end
    end

    // Request sizing and block fit tests.
    assign req_pad  = (req_reg < 16'd2) ? 16'd2 : req_reg;
    assign pad_size = {1'b0, req_pad} + 17'd2;
    assign size16   = size_reg[WW-1:0];
    assign blk_fits = hp_rdata >= size16;
    assign blk_diff = hp_rdata - size16;
    assign take_blk = blk_fits && ((blk_diff == '0) || (blk_diff >= bfha_pkg::MIN_REST))
                      && (blk_diff < fit_slack_reg);
    assign rest_sum = {1'b0, best_reg} + size_reg;
    assign hdr      = rel_reg - AW'(2);
    assign rel_end  = {3'b0, hdr} + {1'b0, hp_rdata};
    assign top_room = {3'b0, top_reg} + {1'b0, size_reg};
    assign coal_end = {1'b0, c_reg} + {1'b0, sz_reg};
    assign j_dec    = j_reg - CW'(1);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        top_next       = top_reg;
        head_next      = head_reg;
        live_next      = live_reg;
        peak_next      = peak_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        op_next        = op_reg;
        req_next       = req_reg;
        rel_next       = rel_reg;
        size_next      = size_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        best_next      = best_reg;
        fit_pred_next  = fit_pred_reg;
        fit_slack_next = fit_slack_reg;
        best_size_next = best_size_reg;
        found_next     = found_reg;
        rest_next      = rest_reg;
        blk_next       = blk_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        v_next         = v_reg;
        last_next      = last_reg;
        c_next         = c_reg;
        sz_next        = sz_reg;
        ok_w_next      = ok_w_reg;
        pay_w_next     = pay_w_reg;
        res_ok_next    = res_ok_reg;
        res_pay_next   = res_pay_reg;
        res_live_next  = res_live_reg;
        res_peak_next  = res_peak_reg;
        res_top_next   = res_top_reg;
        hp_req         = '0;
        nb_re          = 1'b0;
        nb_raddr       = '0;
        nb_we          = 1'b0;
        nb_waddr       = '0;
        nb_wdata       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = op;
                    req_next   = request_bytes;
                    rel_next   = release_offset;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                ok_w_next  = 1'b0;
                pay_w_next = '0;
                if (op_reg == bfha_pkg::OP_ALLOC)
                begin
                    size_next = pad_size;
                    if ((req_reg == '0) || (pad_size > 17'(bfha_pkg::HEAP_BYTES)))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        prev_next      = bfha_pkg::NIL;
                        cur_next       = head_reg;
                        steps_next     = '0;
                        found_next     = 1'b0;
                        fit_slack_next = DIFF_NONE;
                        state_next     = S_TB_CHECK;
                    end
                end
                else if ((rel_reg >= AW'(2)) &&
                         (({1'b0, rel_reg} + 15'd2) <= 15'(bfha_pkg::HEAP_BYTES)))
                begin
                    hp_req.re    = 1'b1;
                    hp_req.raddr = hdr;
                    state_next   = S_REL_SIZE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            // Best-fit walk over the free list.
            S_TB_CHECK:
            begin
                if ((cur_reg == bfha_pkg::NIL) || (steps_reg >= CW'(bfha_pkg::WALK_LIMIT)))
                begin
                    state_next = S_TB_END;
                end
                else
                begin
                    hp_req.re    = 1'b1;
                    hp_req.raddr = word_index(cur_reg);
                    state_next   = S_TB_SIZE;
                end
            end

            S_TB_SIZE:
            begin
                if (take_blk)
                begin
                    best_next      = cur_reg;
                    fit_pred_next  = prev_reg;
                    fit_slack_next = blk_diff;
                    best_size_next = hp_rdata;
                    found_next     = 1'b1;
                end
                if (take_blk && (blk_diff == '0))
                begin
                    state_next = S_TB_END;
                end
                else
                begin
                    hp_req.re    = 1'b1;
                    hp_req.raddr = link_index(cur_reg);
                    state_next   = S_TB_NEXT;
                end
            end

            S_TB_NEXT:
            begin
                prev_next  = cur_reg;
                cur_next   = hp_rdata;
                steps_next = steps_reg + CW'(1);
                state_next = S_TB_CHECK;
            end

            S_TB_END:
            begin
                if (!found_reg)
                begin
                    state_next = S_ALLOC_TOP;
                end
                else if (fit_slack_reg != '0)
                begin
                    // Split: the tail becomes a free block of its own.
                    rest_next    = rest_sum[WW-1:0];
                    hp_req.we    = 1'b1;
                    hp_req.waddr = word_index(rest_sum[WW-1:0]);
                    hp_req.wdata = best_size_reg - size16;
                    state_next   = S_SPLIT_RD;
                end
                else
                begin
                    state_next = S_TB_UNLINK;
                end
            end

            S_SPLIT_RD:
            begin
                hp_req.re    = 1'b1;
                hp_req.raddr = link_index(best_reg);
                state_next   = S_SPLIT_WR;
            end

            S_SPLIT_WR:
            begin
                hp_req.we    = 1'b1;
                hp_req.waddr = link_index(rest_reg);
                hp_req.wdata = hp_rdata;
                state_next   = S_SPLIT_LINK;
            end

            S_SPLIT_LINK:
            begin
                hp_req.we    = 1'b1;
                hp_req.waddr = link_index(best_reg);
                hp_req.wdata = rest_reg;
                state_next   = S_TB_UNLINK;
            end

            S_TB_UNLINK:
            begin
                hp_req.re    = 1'b1;
                hp_req.raddr = link_index(best_reg);
                state_next   = S_TB_RELINK;
            end

            S_TB_RELINK:
            begin
                if (fit_pred_reg != bfha_pkg::NIL)
                begin
                    hp_req.we    = 1'b1;
                    hp_req.waddr = link_index(fit_pred_reg);
                    hp_req.wdata = hp_rdata;
                end
                else
                begin
                    head_next = hp_rdata;
                end
                blk_next   = best_reg;
                state_next = S_ALLOC_FIN;
            end

            // No free block fits: cut from the top.
            S_ALLOC_TOP:
            begin
                if (top_room <= 18'(bfha_pkg::HEAP_BYTES))
                begin
                    blk_next   = {1'b0, top_reg};
                    top_next   = top_reg + size_reg[TW-1:0];
                    state_next = S_ALLOC_FIN;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_ALLOC_FIN:
            begin
                hp_req.we    = 1'b1;
                hp_req.waddr = word_index(blk_reg);
                hp_req.wdata = size16;
                live_next    = live_reg + size_reg[TW-1:0];
                peak_next    = (top_reg > peak_reg) ? top_reg : peak_reg;
                ok_w_next    = 1'b1;
                pay_w_next   = blk_reg[AW-1:0] + AW'(2);
                state_next   = S_EMIT;
            end

            // Release: the header size is in hand.
            S_REL_SIZE:
            begin
                live_next = live_reg - hp_rdata[TW-1:0];
                ok_w_next = 1'b1;
                if (rel_end == {2'b0, top_reg})
                begin
                    top_next   = top_reg - hp_rdata[TW-1:0];
                    state_next = S_EMIT;
                end
                else
                begin
                    hp_req.we    = 1'b1;
                    hp_req.waddr = link_index({2'b0, hdr});
                    hp_req.wdata = head_reg;
                    head_next    = {2'b0, hdr};
                    cur_next     = {2'b0, hdr};
                    n_next       = '0;
                    state_next   = S_DF_CHECK;
                end
            end

            // Collect the free list into the node buffer.
            S_DF_CHECK:
            begin
                if ((cur_reg == bfha_pkg::NIL) || (n_reg >= CW'(bfha_pkg::WALK_LIMIT)))
                begin
                    i_next     = CW'(1);
                    state_next = S_SO_CHECK;
                end
                else
                begin
                    nb_we        = 1'b1;
                    nb_waddr     = n_reg[IW-1:0];
                    nb_wdata     = cur_reg;
                    n_next       = n_reg + CW'(1);
                    hp_req.re    = 1'b1;
                    hp_req.raddr = link_index(cur_reg);
                    state_next   = S_DF_NEXT;
                end
            end

            S_DF_NEXT:
            begin
                cur_next   = hp_rdata;
                state_next = S_DF_CHECK;
            end

            // Insertion sort by address.
            S_SO_CHECK:
            begin
                if (i_reg >= n_reg)
                begin
                    i_next     = '0;
                    k_next     = '0;
                    state_next = S_DD_CHECK;
                end
                else
                begin
                    nb_re      = 1'b1;
                    nb_raddr   = i_reg[IW-1:0];
                    state_next = S_SO_LOADV;
                end
            end

            S_SO_LOADV:
            begin
                v_next     = nb_rd_reg;
                j_next     = i_reg;
                state_next = S_SO_CMP;
            end

            S_SO_CMP:
            begin
                if (j_reg == '0)
                begin
                    nb_we      = 1'b1;
                    nb_waddr   = j_reg[IW-1:0];
                    nb_wdata   = v_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = S_SO_CHECK;
                end
                else
                begin
                    nb_re      = 1'b1;
                    nb_raddr   = j_dec[IW-1:0];
                    state_next = S_SO_TEST;
                end
            end

            S_SO_TEST:
            begin
                nb_we    = 1'b1;
                nb_waddr = j_reg[IW-1:0];
                if (nb_rd_reg > v_reg)
                begin
                    nb_wdata   = nb_rd_reg;
                    j_next     = j_dec;
                    state_next = S_SO_CMP;
                end
                else
                begin
                    nb_wdata   = v_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = S_SO_CHECK;
                end
            end

            // Drop repeated addresses.
            S_DD_CHECK:
            begin
                if (i_reg >= n_reg)
                begin
                    n_next     = k_reg;
                    k_next     = '0;
                    i_next     = '0;
                    state_next = S_CO_CHECK;
                end
                else
                begin
                    nb_re      = 1'b1;
                    nb_raddr   = i_reg[IW-1:0];
                    state_next = S_DD_TEST;
                end
            end

            S_DD_TEST:
            begin
                if ((k_reg == '0) || (last_reg != nb_rd_reg))
                begin
                    nb_we     = 1'b1;
                    nb_waddr  = k_reg[IW-1:0];
                    nb_wdata  = nb_rd_reg;
                    k_next    = k_reg + CW'(1);
                    last_next = nb_rd_reg;
                end
                i_next     = i_reg + CW'(1);
                state_next = S_DD_CHECK;
            end

            // Merge runs of adjacent free blocks.
            S_CO_CHECK:
            begin
                if (i_reg >= n_reg)
                begin
                    state_next = S_LK_START;
                end
                else
                begin
                    nb_re      = 1'b1;
                    nb_raddr   = i_reg[IW-1:0];
                    state_next = S_CO_C;
                end
            end

            S_CO_C:
            begin
                c_next       = nb_rd_reg;
                hp_req.re    = 1'b1;
                hp_req.raddr = word_index(nb_rd_reg);
                state_next   = S_CO_SZ;
            end

            S_CO_SZ:
            begin
                sz_next    = hp_rdata;
                j_next     = i_reg + CW'(1);
                state_next = S_CO_JCHK;
            end

            S_CO_JCHK:
            begin
                if (j_reg < n_reg)
                begin
                    nb_re      = 1'b1;
                    nb_raddr   = j_reg[IW-1:0];
                    state_next = S_CO_JTEST;
                end
                else
                begin
                    state_next = S_CO_WR;
                end
            end

            S_CO_JTEST:
            begin
                if (coal_end == {1'b0, nb_rd_reg})
                begin
                    hp_req.re    = 1'b1;
                    hp_req.raddr = word_index(nb_rd_reg);
                    state_next   = S_CO_ADD;
                end
                else
                begin
                    state_next = S_CO_WR;
                end
            end

            S_CO_ADD:
            begin
                sz_next    = sz_reg + hp_rdata;
                j_next     = j_reg + CW'(1);
                state_next = S_CO_JCHK;
            end

            S_CO_WR:
            begin
                hp_req.we    = 1'b1;
                hp_req.waddr = word_index(c_reg);
                hp_req.wdata = sz_reg;
                if (coal_end == {2'b0, top_reg})
                begin
                    // A trailing free block goes back to the top.
                    top_next   = top_reg - sz_reg[TW-1:0];
                    state_next = S_LK_START;
                end
                else
                begin
                    nb_we      = 1'b1;
                    nb_waddr   = k_reg[IW-1:0];
                    nb_wdata   = c_reg;
                    k_next     = k_reg + CW'(1);
                    i_next     = j_reg;
                    state_next = S_CO_CHECK;
                end
            end

            // Relink the surviving blocks in address order.
            S_LK_START:
            begin
                if (k_reg == '0)
                begin
                    head_next  = bfha_pkg::NIL;
                    state_next = S_EMIT;
                end
                else
                begin
                    nb_re      = 1'b1;
                    nb_raddr   = '0;
                    state_next = S_LK_FIRST;
                end
            end

            S_LK_FIRST:
            begin
                head_next  = nb_rd_reg;
                prev_next  = nb_rd_reg;
                i_next     = CW'(1);
                state_next = S_LK_CHECK;
            end

            S_LK_CHECK:
            begin
                if (i_reg >= k_reg)
                begin
                    hp_req.we    = 1'b1;
                    hp_req.waddr = link_index(prev_reg);
                    hp_req.wdata = bfha_pkg::NIL;
                    state_next   = S_EMIT;
                end
                else
                begin
                    nb_re      = 1'b1;
                    nb_raddr   = i_reg[IW-1:0];
                    state_next = S_LK_WR;
                end
            end

            S_LK_WR:
            begin
                hp_req.we    = 1'b1;
                hp_req.waddr = link_index(prev_reg);
                hp_req.wdata = nb_rd_reg;
                prev_next    = nb_rd_reg;
                i_next       = i_reg + CW'(1);
                state_next   = S_LK_CHECK;
            end

            // Hand the result word to the output register once it is free.
            S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    res_ok_next    = ok_w_reg;
                    res_pay_next   = pay_w_reg;
                    res_live_next  = live_reg;
                    res_peak_next  = peak_reg;
                    res_top_next   = top_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and heap bookkeeping registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            head_reg      <= bfha_pkg::NIL;
            live_reg      <= '0;
            peak_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            head_reg      <= head_next;
            live_reg      <= live_next;
            peak_reg      <= peak_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        req_reg       <= req_next;
        rel_reg       <= rel_next;
        size_reg      <= size_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        steps_reg     <= steps_next;
        best_reg      <= best_next;
        fit_pred_reg  <= fit_pred_next;
        fit_slack_reg <= fit_slack_next;
        best_size_reg <= best_size_next;
        found_reg     <= found_next;
        rest_reg      <= rest_next;
        blk_reg       <= blk_next;
        n_reg         <= n_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        v_reg         <= v_next;
        last_reg      <= last_next;
        c_reg         <= c_next;
        sz_reg        <= sz_next;
        ok_w_reg      <= ok_w_next;
        pay_w_reg     <= pay_w_next;
        res_ok_reg    <= res_ok_next;
        res_pay_reg   <= res_pay_next;
        res_live_reg  <= res_live_next;
        res_peak_reg  <= res_peak_next;
        res_top_reg   <= res_top_next;
    end

    assign req_stall      = (state_reg != S_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign ok             = res_ok_reg;
    assign payload_offset = res_pay_reg;
    assign bytes_in_use   = res_live_reg;
    assign peak_top       = res_peak_reg;
    assign top_pointer    = res_top_reg;

endmodule

`default_nettype wire
